// File: hw/rtl/hcd_pkg.sv
// ----------------------------------------------------------------------------
// hcd_pkg: shared types and constants of the Harris corner detector
// Holds the controller states, the command and status bundles between the
// controller and the datapath, and the 3x3 kernel tables.
// ----------------------------------------------------------------------------
package hcd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4095;
    localparam int RING_LEN   = 2 * MAX_WIDTH + 4;
    localparam int RING_AW    = $clog2(RING_LEN);
    localparam int BEAT_W     = 23;
    localparam int NUM_TAPS   = 9;
    localparam int LAST_STEP  = 10;

    localparam logic [28:0] THR_SCALE = 29'd429981696;

    typedef logic [RING_AW-1:0] ring_addr_t;

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT,
        CFG_COLOR_INPUT,
        CFG_HARRIS_K,
        CFG_RESPONSE_THRESHOLD
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_BLUR,
        PH_GRAD,
        PH_FLAG
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRAY,
        ST_BLUR,
        ST_GRAD,
        ST_FLAG,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_ADV
    } state_t;

    typedef struct packed {
        logic       start;
        logic       gray_we;
        phase_t     phase;
        logic       issue;
        logic [3:0] tap;
        logic       clear;
        logic       write_back;
        logic       mul1;
        logic       mul2;
        logic       mul3;
        logic       mul4;
        logic       advance;
    } cmd_t;

    typedef struct packed {
        logic ignore;
        logic out_busy;
    } status_t;

    // Row offset of a tap within the 3x3 window.
    function automatic logic signed [1:0] tap_dy(input logic [3:0] tap);
        logic signed [1:0] d;
        unique case (tap)
            4'd0, 4'd1, 4'd2: d = -2'sd1;
            4'd6, 4'd7, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    // Column offset of a tap within the 3x3 window.
    function automatic logic signed [1:0] tap_dx(input logic [3:0] tap);
        logic signed [1:0] d;
        unique case (tap)
            4'd0, 4'd3, 4'd6: d = -2'sd1;
            4'd2, 4'd5, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] blur_weight(input logic [3:0] tap);
        logic [2:0] w;
        unique case (tap)
            4'd0, 4'd2, 4'd6, 4'd8: w = 3'd1;
            4'd4:                   w = 3'd4;
            default:                w = 3'd2;
        endcase
        return w;
    endfunction

    function automatic logic signed [2:0] sobel_x(input logic [3:0] tap);
        logic signed [2:0] w;
        unique case (tap)
            4'd0, 4'd2: w = -3'sd1;
            4'd1:       w = -3'sd2;
            4'd6, 4'd8: w = 3'sd1;
            4'd7:       w = 3'sd2;
            default:    w = 3'sd0;
        endcase
        return w;
    endfunction

    function automatic logic signed [2:0] sobel_y(input logic [3:0] tap);
        logic signed [2:0] w;
        unique case (tap)
            4'd0, 4'd6: w = -3'sd1;
            4'd3:       w = -3'sd2;
            4'd2, 4'd8: w = 3'sd1;
            4'd5:       w = 3'sd2;
            default:    w = 3'sd0;
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/hcd_ctrl.sv
// ----------------------------------------------------------------------------
// hcd_ctrl: sequencer of the Harris corner detector
// Steps one item through gray store, blur, gradient and response phases,
// issuing one line-buffer read per cycle, then the response multiplies.
// ----------------------------------------------------------------------------
module hcd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hcd_pkg::status_t st,
    output hcd_pkg::cmd_t    cmd
);

    hcd_pkg::state_t state_reg, state_next;
    logic [3:0]      cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcd_pkg::ST_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            hcd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (!st.ignore)
                        state_next = hcd_pkg::ST_GRAY;
                end
            end
            hcd_pkg::ST_GRAY:
            begin
                cmd.gray_we = 1'b1;
                cnt_next    = 4'd0;
                state_next  = hcd_pkg::ST_BLUR;
            end
            hcd_pkg::ST_BLUR, hcd_pkg::ST_GRAD, hcd_pkg::ST_FLAG:
            begin
                if (state_reg == hcd_pkg::ST_BLUR)
                    cmd.phase = hcd_pkg::PH_BLUR;
                else if (state_reg == hcd_pkg::ST_GRAD)
                    cmd.phase = hcd_pkg::PH_GRAD;
                else
                    cmd.phase = hcd_pkg::PH_FLAG;
                cmd.issue = (cnt_reg < 4'(hcd_pkg::NUM_TAPS));
                cmd.tap   = cnt_reg;
                cmd.clear = (cnt_reg == 4'd0);
                if (cnt_reg == 4'(hcd_pkg::LAST_STEP))
                begin
                    cmd.write_back = 1'b1;
                    cnt_next       = 4'd0;
                    if (state_reg == hcd_pkg::ST_BLUR)
                        state_next = hcd_pkg::ST_GRAD;
                    else if (state_reg == hcd_pkg::ST_GRAD)
                        state_next = hcd_pkg::ST_FLAG;
                    else
                        state_next = hcd_pkg::ST_MUL1;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            hcd_pkg::ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = hcd_pkg::ST_MUL2;
            end
            hcd_pkg::ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = hcd_pkg::ST_MUL3;
            end
            hcd_pkg::ST_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = hcd_pkg::ST_MUL4;
            end
            hcd_pkg::ST_MUL4:
            begin
                cmd.mul4   = 1'b1;
                state_next = hcd_pkg::ST_ADV;
            end
            hcd_pkg::ST_ADV:
            begin
                // The result register must be free before a new result lands.
                if (!st.out_busy)
                begin
                    cmd.advance = 1'b1;
                    state_next  = hcd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/hcd_datapath.sv
// ----------------------------------------------------------------------------
// hcd_datapath: line buffers, filters and response test
// Three ring buffers hold gray, blurred and gradient pixels. A shared read
// port walks the 3x3 window of one stage per phase; accumulators and a
// four-step multiply chain produce the corner decision.
// ----------------------------------------------------------------------------
module hcd_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hcd_pkg::cmd_t         cmd,
    output hcd_pkg::status_t      st,
    input  logic [10:0]           cfg_width,
    input  logic [11:0]           cfg_height,
    input  logic                  cfg_color,
    input  logic [13:0]           cfg_k,
    input  logic [29:0]           cfg_thr,
    input  logic [7:0]            chan_blue,
    input  logic [7:0]            chan_green,
    input  logic [7:0]            chan_red,
    input  logic                  is_filler,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [11:0]           pixel_row,
    output logic [9:0]            pixel_col,
    output logic                  corner_flag,
    output logic                  last_of_frame
);

    localparam int BW = hcd_pkg::BEAT_W;
    localparam int RL = hcd_pkg::RING_LEN;
    localparam int AW = hcd_pkg::RING_AW;
    // Truncating divide by three of a sum of at most 765.
    localparam logic [19:0] GRAY_RECIP = 20'd683;

    // Frame geometry.
    logic [10:0]   fw_reg;
    logic [11:0]   fh_reg;
    logic [BW-1:0] total_reg;
    logic [11:0]   d1_reg, d2_reg, d3_reg;
    logic [BW-1:0] beat_reg;
    hcd_pkg::ring_addr_t bptr_reg;
    logic          active_reg;

    logic [11:0] qrow_reg, srow_reg, prow_reg;
    logic [9:0]  qcol_reg, scol_reg, pcol_reg;

    logic [7:0] blue_reg, green_reg, red_reg;
    logic       filler_reg;

    logic [7:0]  gray_mem [RL];
    logic [7:0]  blur_mem [RL];
    logic [21:0] grad_mem [RL];
    logic [7:0]  g_rd_reg, b_rd_reg;
    logic [21:0] x_rd_reg;

    logic          v1_reg, in1_reg, v2_reg;
    logic [3:0]    tap1_reg;
    hcd_pkg::phase_t ph1_reg;
    hcd_pkg::ring_addr_t center_reg;

    logic [11:0]        acc_b_reg;
    logic signed [11:0] gx_reg, gy_reg;
    logic signed [21:0] pxx_reg, pyy_reg, pxy_reg;
    logic signed [24:0] sxx_reg, syy_reg, sxy_reg;

    logic [47:0] det_a_reg, det_reg;
    logic [49:0] sq_reg, tr2_reg;
    logic [24:0] tr_reg;
    logic [58:0] thr_reg;
    logic [63:0] ktr_reg, lhs_reg;
    logic        flag_reg;

    logic          out_valid_reg;
    logic [11:0]   out_row_reg;
    logic [9:0]    out_col_reg;
    logic          out_flag_reg, out_last_reg;

    // Frame bookkeeping.
    logic          frame_done, new_frame;
    logic [BW-1:0] lin_q, lin_s, lin_p;
    logic          in_q, in_s, in_p;

    assign frame_done = (beat_reg >= total_reg);
    assign new_frame  = !active_reg || frame_done;
    assign st.ignore  = is_filler && (!active_reg || !frame_done);
    assign st.out_busy = out_valid_reg && !out_ready;

    assign lin_q = beat_reg - BW'(d1_reg);
    assign lin_s = beat_reg - BW'(d2_reg);
    assign lin_p = beat_reg - BW'(d3_reg);
    assign in_q  = (beat_reg >= BW'(d1_reg)) && (lin_q < total_reg);
    assign in_s  = (beat_reg >= BW'(d2_reg)) && (lin_s < total_reg);
    assign in_p  = (beat_reg >= BW'(d3_reg)) && (lin_p < total_reg);

    // Window address and border test of the tap now being read.
    logic [11:0]         cur_row;
    logic [9:0]          cur_col;
    logic [11:0]         cur_d;
    logic signed [1:0]   dy, dx;
    logic [13:0]         off, asum;
    hcd_pkg::ring_addr_t rd_addr;
    logic                tap_in;

    always_comb
    begin
        unique case (cmd.phase)
            hcd_pkg::PH_BLUR:
            begin
                cur_row = qrow_reg;
                cur_col = qcol_reg;
                cur_d   = d1_reg;
            end
            hcd_pkg::PH_GRAD:
            begin
                cur_row = srow_reg;
                cur_col = scol_reg;
                cur_d   = d2_reg;
            end
            hcd_pkg::PH_FLAG:
            begin
                cur_row = prow_reg;
                cur_col = pcol_reg;
                cur_d   = d3_reg;
            end
            default:
            begin
                cur_row = 12'd0;
                cur_col = 10'd0;
                cur_d   = 12'd0;
            end
        endcase
        dy  = hcd_pkg::tap_dy(cmd.tap);
        dx  = hcd_pkg::tap_dx(cmd.tap);
        off = 14'(cur_d);
        if (dy < 0)
            off = off + 14'(fw_reg);
        else if (dy > 0)
            off = off - 14'(fw_reg);
        if (dx < 0)
            off = off + 14'd1;
        else if (dx > 0)
            off = off - 14'd1;
        asum = 14'(bptr_reg) + 14'(2 * RL) - off;
        if (asum >= 14'(2 * RL))
            rd_addr = AW'(asum - 14'(2 * RL));
        else if (asum >= 14'(RL))
            rd_addr = AW'(asum - 14'(RL));
        else
            rd_addr = AW'(asum);
        tap_in = !((dy < 0) && (cur_row == 12'd0))
              && !((dy > 0) && (cur_row == fh_reg - 12'd1))
              && !((dx < 0) && (cur_col == 10'd0))
              && !((dx > 0) && ({1'b0, cur_col} == fw_reg - 11'd1));
    end

    // Gray conversion of the held pixel.
    logic [9:0]  chan_sum;
    logic [19:0] gray_prod;
    logic [7:0]  gray_val;

    assign chan_sum  = {2'b00, blue_reg} + {2'b00, green_reg} + {2'b00, red_reg};
    assign gray_prod = 20'(chan_sum) * GRAY_RECIP;
    assign gray_val  = cfg_color ? gray_prod[18:11] : red_reg;

    // Frame and position state.
    logic [10:0] w_clamp;
    logic [11:0] h_clamp;

    assign w_clamp = (cfg_width < 11'd3) ? 11'd3
                   : ((cfg_width > 11'(hcd_pkg::MAX_WIDTH)) ? 11'(hcd_pkg::MAX_WIDTH)
                                                           : cfg_width);
    assign h_clamp = (cfg_height < 12'd3) ? 12'd3
                   : ((cfg_height > 12'(hcd_pkg::MAX_HEIGHT)) ? 12'(hcd_pkg::MAX_HEIGHT)
                                                             : cfg_height);

    logic p_last, p_border;
    assign p_last   = (lin_p == total_reg - BW'(1));
    assign p_border = (prow_reg == 12'd0) || (prow_reg == fh_reg - 12'd1)
                   || (pcol_reg == 10'd0) || ({1'b0, pcol_reg} == fw_reg - 11'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg     <= 11'd3;
            fh_reg     <= 12'd3;
            total_reg  <= BW'(9);
            d1_reg     <= 12'd4;
            d2_reg     <= 12'd8;
            d3_reg     <= 12'd12;
            beat_reg   <= '0;
            bptr_reg   <= '0;
            active_reg <= 1'b0;
            qrow_reg   <= '0;
            srow_reg   <= '0;
            prow_reg   <= '0;
            qcol_reg   <= '0;
            scol_reg   <= '0;
            pcol_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.start && !is_filler && new_frame)
            begin
                fw_reg     <= w_clamp;
                fh_reg     <= h_clamp;
                total_reg  <= BW'(w_clamp) * BW'(h_clamp);
                d1_reg     <= 12'(w_clamp) + 12'd1;
                d2_reg     <= 12'({w_clamp, 1'b0}) + 12'd2;
                d3_reg     <= 12'(w_clamp) + 12'({w_clamp, 1'b0}) + 12'd3;
                beat_reg   <= '0;
                bptr_reg   <= '0;
                active_reg <= 1'b1;
                qrow_reg   <= '0;
                srow_reg   <= '0;
                prow_reg   <= '0;
                qcol_reg   <= '0;
                scol_reg   <= '0;
                pcol_reg   <= '0;
            end
            if (cmd.advance)
            begin
                if (in_p)
                begin
                    out_valid_reg <= 1'b1;
                    if (p_last)
                        active_reg <= 1'b0;
                end
                if (in_q)
                begin
                    if ({1'b0, qcol_reg} == fw_reg - 11'd1)
                    begin
                        qcol_reg <= '0;
                        qrow_reg <= qrow_reg + 12'd1;
                    end
                    else
                    begin
                        qcol_reg <= qcol_reg + 10'd1;
                    end
                end
                if (in_s)
                begin
                    if ({1'b0, scol_reg} == fw_reg - 11'd1)
                    begin
                        scol_reg <= '0;
                        srow_reg <= srow_reg + 12'd1;
                    end
                    else
                    begin
                        scol_reg <= scol_reg + 10'd1;
                    end
                end
                if (in_p)
                begin
                    if ({1'b0, pcol_reg} == fw_reg - 11'd1)
                    begin
                        pcol_reg <= '0;
                        prow_reg <= prow_reg + 12'd1;
                    end
                    else
                    begin
                        pcol_reg <= pcol_reg + 10'd1;
                    end
                end
                beat_reg <= beat_reg + BW'(1);
                bptr_reg <= (bptr_reg == AW'(RL - 1)) ? '0 : bptr_reg + AW'(1);
            end
        end
    end

    // Held item and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            blue_reg   <= chan_blue;
            green_reg  <= chan_green;
            red_reg    <= chan_red;
            filler_reg <= is_filler;
        end
        if (cmd.advance && in_p)
        begin
            out_row_reg  <= prow_reg;
            out_col_reg  <= pcol_reg;
            out_flag_reg <= flag_reg && !p_border;
            out_last_reg <= p_last;
        end
    end

    // Line buffers.
    always_ff @(posedge clk)
    begin
        if (cmd.gray_we && !filler_reg)
            gray_mem[bptr_reg] <= gray_val;
        if (cmd.issue)
            g_rd_reg <= gray_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_back && (cmd.phase == hcd_pkg::PH_BLUR) && in_q)
            blur_mem[center_reg] <= acc_b_reg[11:4];
        if (cmd.issue)
            b_rd_reg <= blur_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_back && (cmd.phase == hcd_pkg::PH_GRAD) && in_s)
            grad_mem[center_reg] <= {gy_reg[10:0], gx_reg[10:0]};
        if (cmd.issue)
            x_rd_reg <= grad_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg && (ph1_reg == hcd_pkg::PH_FLAG);
        end
    end

    // Window accumulation.
    logic signed [11:0] wx, wy, bv;
    logic signed [10:0] gxv, gyv;

    assign wx  = 12'(hcd_pkg::sobel_x(tap1_reg));
    assign wy  = 12'(hcd_pkg::sobel_y(tap1_reg));
    assign bv  = $signed({4'b0000, b_rd_reg});
    assign gxv = $signed(x_rd_reg[10:0]);
    assign gyv = $signed(x_rd_reg[21:11]);

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            tap1_reg <= cmd.tap;
            in1_reg  <= tap_in;
            ph1_reg  <= cmd.phase;
            if (cmd.tap == 4'd4)
                center_reg <= rd_addr;
        end
        if (cmd.clear)
        begin
            acc_b_reg <= '0;
            gx_reg    <= '0;
            gy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
        end
        else
        begin
            if (v1_reg)
            begin
                unique case (ph1_reg)
                    hcd_pkg::PH_BLUR:
                    begin
                        if (in1_reg)
                            acc_b_reg <= acc_b_reg
                                       + 12'(g_rd_reg) * 12'(hcd_pkg::blur_weight(tap1_reg));
                    end
                    hcd_pkg::PH_GRAD:
                    begin
                        if (in1_reg)
                        begin
                            gx_reg <= gx_reg + 12'(wx * bv);
                            gy_reg <= gy_reg + 12'(wy * bv);
                        end
                    end
                    hcd_pkg::PH_FLAG:
                    begin
                        pxx_reg <= gxv * gxv;
                        pyy_reg <= gyv * gyv;
                        pxy_reg <= gxv * gyv;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (v2_reg)
            begin
                sxx_reg <= sxx_reg + 25'(pxx_reg);
                syy_reg <= syy_reg + 25'(pyy_reg);
                sxy_reg <= sxy_reg + 25'(pxy_reg);
            end
        end
    end

    // Response: det * 2^16 against k * tr^2 + threshold * 81^2 * 2^16.
    logic signed [49:0] sq_s;
    assign sq_s = sxy_reg * sxy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            det_a_reg <= 48'(sxx_reg[23:0]) * 48'(syy_reg[23:0]);
            sq_reg    <= sq_s;
            tr_reg    <= 25'(sxx_reg[23:0]) + 25'(syy_reg[23:0]);
        end
        if (cmd.mul2)
        begin
            det_reg <= det_a_reg - sq_reg[47:0];
            tr2_reg <= 50'(tr_reg) * 50'(tr_reg);
            thr_reg <= 59'(cfg_thr) * 59'(hcd_pkg::THR_SCALE);
        end
        if (cmd.mul3)
        begin
            ktr_reg <= 64'(cfg_k) * 64'(tr2_reg);
            lhs_reg <= {det_reg, 16'h0000};
        end
        if (cmd.mul4)
            flag_reg <= (lhs_reg > ktr_reg + 64'(thr_reg));
    end

    assign out_valid     = out_valid_reg;
    assign pixel_row     = out_row_reg;
    assign pixel_col     = out_col_reg;
    assign corner_flag   = out_flag_reg;
    assign last_of_frame = out_last_reg;

endmodule

// File: hw/rtl/harris_corner_detector_top.sv
// ----------------------------------------------------------------------------
// harris_corner_detector_top: Harris corner detector on a pixel stream
// Configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Each pixel item, and each filler item that still flushes a frame, steps the
// sequencer through gray store, blur, gradient, response and multiply states;
// the result register is loaded when it leaves the advance state, after any
// wait for the previous result to be taken, and the next item is accepted in
// the cycle after. A filler item that is ignored is taken in the idle state.
// The time per item is set by the single read port of the line buffers: blur,
// gradient and response each walk a 3x3 window at one read per cycle, followed
// by four multiply steps. The result for pixel p appears at the item that is
// 3*width+3 items after it, so 3*width+3 filler items after the last pixel
// flush the frame. Frame size is taken when a frame's first pixel arrives.
module harris_corner_detector_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [29:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  chan_blue,
    input  logic [7:0]  chan_green,
    input  logic [7:0]  chan_red,
    input  logic        is_filler,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] pixel_row,
    output logic [9:0]  pixel_col,
    output logic        corner_flag,
    output logic        last_of_frame
);

    logic [10:0] frame_width_reg;
    logic [11:0] frame_height_reg;
    logic        color_input_reg;
    logic [13:0] harris_k_reg;
    logic [29:0] response_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg        <= 11'd640;
            frame_height_reg       <= 12'd480;
            color_input_reg        <= 1'b1;
            harris_k_reg           <= 14'd2621;
            response_threshold_reg <= 30'd30000;
        end
        else if (cfg_write)
        begin
            unique case (hcd_pkg::cfg_idx_t'(cfg_index))
                hcd_pkg::CFG_FRAME_WIDTH:        frame_width_reg <= cfg_data[10:0];
                hcd_pkg::CFG_FRAME_HEIGHT:       frame_height_reg <= cfg_data[11:0];
                hcd_pkg::CFG_COLOR_INPUT:        color_input_reg <= cfg_data[0];
                hcd_pkg::CFG_HARRIS_K:           harris_k_reg <= cfg_data[13:0];
                hcd_pkg::CFG_RESPONSE_THRESHOLD: response_threshold_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    hcd_pkg::cmd_t    cmd;
    hcd_pkg::status_t st;

    hcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    hcd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .cfg_width     (frame_width_reg),
        .cfg_height    (frame_height_reg),
        .cfg_color     (color_input_reg),
        .cfg_k         (harris_k_reg),
        .cfg_thr       (response_threshold_reg),
        .chan_blue     (chan_blue),
        .chan_green    (chan_green),
        .chan_red      (chan_red),
        .is_filler     (is_filler),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .corner_flag   (corner_flag),
        .last_of_frame (last_of_frame)
    );

    // An item that is not ignored keeps the block busy for the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !st.ignore |=> !in_ready)
        else $error("block took a new item right after a pixel item");

    // A waiting result stays valid and unchanged until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({pixel_row, pixel_col, corner_flag, last_of_frame}))
        else $error("result changed or dropped while waiting");

    // Pixels on the top row or the left column are never flagged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && corner_flag |-> (pixel_row != 12'd0) && (pixel_col != 10'd0))
        else $error("corner flagged on a border pixel");

endmodule

// File: tb/sv/harris_corner_detector_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// harris_corner_detector_top_tb: self-checking bench for the corner detector
// Streams small random frames, flush fillers and malformed sequences into the
// block, predicts every result with a behavioral copy of the pixel pipeline
// and compares row, column, flag and end-of-frame marker in order.
// ----------------------------------------------------------------------------
module harris_corner_detector_top_tb;

    localparam int  HALF_PERIOD = 6;
    localparam int  DRAIN_CYCLES = 80;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint unsigned RESP_SCALE = 64'd429981696;

    localparam int BLUR_W[9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
    localparam int GX_W[9]   = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
    localparam int GY_W[9]   = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       filler;
    } pixel_item_t;

    typedef struct packed {
        logic [11:0] row;
        logic [9:0]  col;
        logic        flag;
        logic        last;
    } corner_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [29:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  chan_blue;
    logic [7:0]  chan_green;
    logic [7:0]  chan_red;
    logic        is_filler;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] pixel_row;
    logic [9:0]  pixel_col;
    logic        corner_flag;
    logic        last_of_frame;

    pixel_item_t    pixel_queue[$];
    corner_result_t expected_results[$];
    int             errors;
    int             items_queued;
    int             send_idle_pct;
    int             recv_idle_pct;
    longint         cycle_count;

    // Configuration as the block sees it.
    int unsigned cfg_width, cfg_height, cfg_color, cfg_k, cfg_thr;

    // Pipeline state of the behavioral copy.
    logic [7:0]  gray_ring[hcd_pkg::RING_LEN];
    logic [7:0]  blur_ring[hcd_pkg::RING_LEN];
    logic [21:0] grad_ring[hcd_pkg::RING_LEN];
    longint      beat_no;
    bit          frame_open;
    longint      cur_w, cur_h;

    harris_corner_detector_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .chan_blue     (chan_blue),
        .chan_green    (chan_green),
        .chan_red      (chan_red),
        .is_filler     (is_filler),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .corner_flag   (corner_flag),
        .last_of_frame (last_of_frame)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    function automatic int ring_ix(longint lin);
        return int'(lin % hcd_pkg::RING_LEN);
    endfunction

    function automatic bit in_frame(longint r, longint c);
        return r >= 0 && r < cur_h && c >= 0 && c < cur_w;
    endfunction

    function automatic logic [7:0] blur_at(longint q);
        longint r, c;
        int     acc;
        r = q / cur_w;
        c = q % cur_w;
        acc = 0;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
                if (in_frame(r + dy, c + dx))
                    acc += BLUR_W[(dy + 1) * 3 + dx + 1] *
                           int'(gray_ring[ring_ix((r + dy) * cur_w + c + dx)]);
        return 8'(acc >> 4);
    endfunction

    function automatic logic [21:0] grad_at(longint s);
        longint r, c;
        int     gx, gy, v;
        r = s / cur_w;
        c = s % cur_w;
        gx = 0;
        gy = 0;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
                if (in_frame(r + dy, c + dx))
                begin
                    v = int'(blur_ring[ring_ix((r + dy) * cur_w + c + dx)]);
                    gx += GX_W[(dy + 1) * 3 + dx + 1] * v;
                    gy += GY_W[(dy + 1) * 3 + dx + 1] * v;
                end
        return {11'(gy), 11'(gx)};
    endfunction

    function automatic logic corner_at(longint p);
        longint r, c, gx, gy, sxx, syy, sxy;
        longint unsigned det, tr, lhs, rhs;
        logic [21:0] g;
        r = p / cur_w;
        c = p % cur_w;
        if (r < 1 || r > cur_h - 2 || c < 1 || c > cur_w - 2)
            return 1'b0;
        sxx = 0;
        syy = 0;
        sxy = 0;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
            begin
                g = grad_ring[ring_ix((r + dy) * cur_w + c + dx)];
                gx = longint'($signed(g[10:0]));
                gy = longint'($signed(g[21:11]));
                sxx += gx * gx;
                syy += gy * gy;
                sxy += gx * gy;
            end
        det = longint'(sxx * syy) - longint'(sxy * sxy);
        tr = sxx + syy;
        lhs = det << 16;
        rhs = longint'(cfg_k) * (tr * tr) + longint'(cfg_thr) * RESP_SCALE;
        return lhs > rhs;
    endfunction

    // Advances the pipeline copy by one accepted item.
    task automatic predict_corner(input pixel_item_t it);
        longint         total, q, s, p;
        corner_result_t res;
        if (it.filler)
        begin
            if (!frame_open || beat_no < cur_w * cur_h)
                return;
        end
        else if (!frame_open || beat_no >= cur_w * cur_h)
        begin
            cur_w = cfg_width < 3 ? 3 : (cfg_width > hcd_pkg::MAX_WIDTH ?
                                         hcd_pkg::MAX_WIDTH : cfg_width);
            cur_h = cfg_height < 3 ? 3 : (cfg_height > hcd_pkg::MAX_HEIGHT ?
                                          hcd_pkg::MAX_HEIGHT : cfg_height);
            beat_no = 0;
            frame_open = 1'b1;
        end
        total = cur_w * cur_h;
        if (!it.filler)
            gray_ring[ring_ix(beat_no)] = cfg_color ?
                8'((int'(it.blue) + int'(it.green) + int'(it.red)) / 3) : it.red;
        q = beat_no - (cur_w + 1);
        s = q - (cur_w + 1);
        p = s - (cur_w + 1);
        if (q >= 0 && q < total)
            blur_ring[ring_ix(q)] = blur_at(q);
        if (s >= 0 && s < total)
            grad_ring[ring_ix(s)] = grad_at(s);
        if (p >= 0 && p < total)
        begin
            res.row = 12'(p / cur_w);
            res.col = 10'(p % cur_w);
            res.flag = corner_at(p);
            res.last = (p == total - 1);
            expected_results.push_back(res);
            if (res.last)
                frame_open = 1'b0;
        end
        beat_no++;
    endtask

    // Sender: presents queued items and feeds each accepted one to the predictor.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            chan_blue <= '0;
            chan_green <= '0;
            chan_red <= '0;
            is_filler <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                predict_corner({chan_blue, chan_green, chan_red, is_filler});
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pixel_queue.pop_front();
                chan_blue <= nxt.blue;
                chan_green <= nxt.green;
                chan_red <= nxt.red;
                is_filler <= nxt.filler;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure and in-order comparison.
    always @(posedge clk or negedge rst_n)
    begin
        corner_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result at row %0d col %0d with nothing expected",
                           pixel_row, pixel_col);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (pixel_row !== want.row)
                    begin
                        $error("pixel_row expected %0d actual %0d", want.row, pixel_row);
                        errors++;
                    end
                    if (pixel_col !== want.col)
                    begin
                        $error("pixel_col expected %0d actual %0d", want.col, pixel_col);
                        errors++;
                    end
                    if (corner_flag !== want.flag)
                    begin
                        $error("corner_flag expected %0d actual %0d", want.flag, corner_flag);
                        errors++;
                    end
                    if (last_of_frame !== want.last)
                    begin
                        $error("last_of_frame expected %0d actual %0d",
                               want.last, last_of_frame);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("harris_corner_detector_top: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input hcd_pkg::cfg_idx_t idx, input int unsigned value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 30'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            hcd_pkg::CFG_FRAME_WIDTH:        cfg_width = value & 32'h7FF;
            hcd_pkg::CFG_FRAME_HEIGHT:       cfg_height = value & 32'hFFF;
            hcd_pkg::CFG_COLOR_INPUT:        cfg_color = value & 32'h1;
            hcd_pkg::CFG_HARRIS_K:           cfg_k = value & 32'h3FFF;
            hcd_pkg::CFG_RESPONSE_THRESHOLD: cfg_thr = value & 32'h3FFF_FFFF;
            default:                ;
        endcase
    endtask

    task automatic queue_item(input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r, input logic fill);
        pixel_queue.push_back({b, g, r, fill});
        items_queued++;
    endtask

    // Queues one frame: pattern 0 random, 1 extremes, 2 blocky shapes.
    // Stray fillers inside the frame are ignored by the block.
    task automatic queue_frame(input int w, input int h, input int pattern,
                               input int flush, input int stray_pct);
        logic [7:0] v;
        for (int i = 0; i < w * h; i++)
        begin
            if ($urandom_range(99) < stray_pct)
                queue_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            case (pattern)
                1:       v = ((i / w + i % w) % 2) ? 8'hFF : 8'h00;
                2:       v = ((i / w) >= h / 2 && (i % w) >= w / 2) ? 8'hF0 : 8'h10;
                default: v = 8'($urandom);
            endcase
            if (pattern == 0)
                queue_item(8'($urandom), 8'($urandom), v, 1'b0);
            else
                queue_item(v, v, v, 1'b0);
        end
        for (int i = 0; i < flush; i++)
            queue_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    endtask

    task automatic wait_drained();
        while (pixel_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_frame_phase();
        int w, h, pat;
        w = $urandom_range(10);
        h = $urandom_range(7);
        write_reg(hcd_pkg::CFG_FRAME_WIDTH, w);
        write_reg(hcd_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(hcd_pkg::CFG_COLOR_INPUT, $urandom_range(1));
        write_reg(hcd_pkg::CFG_HARRIS_K, $urandom_range(4) == 0 ? $urandom_range(16383) :
                                         $urandom_range(4000));
        write_reg(hcd_pkg::CFG_RESPONSE_THRESHOLD, $urandom_range(3) == 0 ? $urandom :
                                                   $urandom_range(3000));
        w = w < 3 ? 3 : w;
        h = h < 3 ? 3 : h;
        pat = $urandom_range(5) == 0 ? 2 : 0;
        if ($urandom_range(5) == 0)
        begin
            // Cut the flush short and let the next frame's pixels arrive early.
            queue_frame(w, h, pat, $urandom_range(3 * w + 2), 5);
            queue_frame(w, h, 0, 3 * w + 3, 0);
        end
        else
            queue_frame(w, h, pat, 3 * w + 3, $urandom_range(1) * 5);
        if ($urandom_range(3) == 0)
            queue_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        items_queued = 0;
        cycle_count = 0;
        send_idle_pct = 9;
        recv_idle_pct = 75;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cfg_width = 640;
        cfg_height = 480;
        cfg_color = 1;
        cfg_k = 2621;
        cfg_thr = 30000;
        frame_open = 1'b0;
        beat_no = 0;
        cur_w = 3;
        cur_h = 3;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: clamped 3x3 frame of extremes with zero k and threshold,
        // fillers while idle, then gray taken from red alone.
        write_reg(hcd_pkg::CFG_FRAME_WIDTH, 0);
        write_reg(hcd_pkg::CFG_FRAME_HEIGHT, 0);
        write_reg(hcd_pkg::CFG_HARRIS_K, 0);
        write_reg(hcd_pkg::CFG_RESPONSE_THRESHOLD, 0);
        queue_item(8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_frame(3, 3, 1, 12, 0);
        wait_drained();
        write_reg(hcd_pkg::CFG_COLOR_INPUT, 0);
        write_reg(hcd_pkg::CFG_FRAME_WIDTH, 4);
        write_reg(hcd_pkg::CFG_FRAME_HEIGHT, 3);
        queue_item(8'h00, 8'hFF, 8'hFF, 1'b0);
        queue_item(8'hFF, 8'h00, 8'h00, 1'b1);
        queue_frame(4, 3, 2, 15, 0);
        wait_drained();
        write_reg(hcd_pkg::CFG_COLOR_INPUT, 1);

        while (items_queued < 380)
            random_frame_phase();
        send_idle_pct = 75;
        recv_idle_pct = 9;
        while (items_queued < 720)
            random_frame_phase();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) random_frame_phase();

        // Largest k and threshold on a small frame.
        write_reg(hcd_pkg::CFG_FRAME_WIDTH, 10);
        write_reg(hcd_pkg::CFG_FRAME_HEIGHT, 3);
        write_reg(hcd_pkg::CFG_HARRIS_K, 16383);
        write_reg(hcd_pkg::CFG_RESPONSE_THRESHOLD, 30'h3FFF_FFFF);
        queue_frame(10, 3, 0, 3 * 10 + 3, 0);
        wait_drained();

        if (errors == 0)
            $display("harris_corner_detector_top: match");
        else
            $display("harris_corner_detector_top: mismatch");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/hcd_pkg.sv
hw/rtl/hcd_ctrl.sv
hw/rtl/hcd_datapath.sv
hw/rtl/harris_corner_detector_top.sv
tb/sv/harris_corner_detector_top_tb.sv
